>>> src/tfb_pkg.sv
// ----------------------------------------------------------------------------
// tfb_pkg: shared constants of the telemetry frame builder.
// Holds the frame sync byte, the configuration register indexes and their
// reset values, and the width of the configuration register index.
// ----------------------------------------------------------------------------
package tfb_pkg;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSourceAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDestAddr   = 2'd1;

  // Reset values of the address registers.
  localparam logic [7:0] SourceAddrReset = 8'h01;
  localparam logic [7:0] DestAddrReset   = 8'hFE;

  // First byte of every frame.
  localparam logic [7:0] FrameSync = 8'hAB;

endpackage : tfb_pkg

>>> src/telemetry_frame_builder.sv
// ----------------------------------------------------------------------------
// telemetry_frame_builder: telemetry frame serialiser with dual checksum.
//
// Input channel (in_valid_i / in_stall_o): one item per word. An item with
// start_frame_i set opens a frame of item_count_i payload items and emits the
// header 0xAB, source, destination, frame_id_i and the 16-bit little-endian
// payload length, followed by its payload. Later items add two bytes, low
// byte first; the final item adds its low byte and then the byte sum and the
// sum of sums. A non-start item while no frame is open is taken and dropped.
// Output channel (out_valid_o / out_stall_i): one frame byte per word, with
// frame_end_o set on the second checksum byte.
// Configuration channel (cfg_valid_i / cfg_ready_o): always ready; index 0 is
// the source address, index 1 the destination address, others are ignored.
// Throughput is one output byte per cycle when unstalled, set by the output
// register. The sequencer spends two bytes on a middle item, three on a final
// one, eight on a start item, nine on a single-item frame. The next item is
// taken in the cycle the sequencer emits the last byte of the current one. The
// first byte passes the job register, then the output register. Reset empties
// both stages, closes any frame and restores the address registers. While the
// receiver stalls, the output word holds and the sequencer waits.
// ----------------------------------------------------------------------------
module telemetry_frame_builder #(
  parameter int unsigned MAX_ITEMS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  // Input item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        start_frame_i,
  input  logic [7:0]                  frame_id_i,
  input  logic [7:0]                  item_count_i,
  input  logic [15:0]                 payload_value_i,
  // Output byte channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        frame_end_o
);
  import tfb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  // Byte positions of the sequencer.
  typedef enum logic [3:0] {
    StSync,
    StSrc,
    StDst,
    StId,
    StLenLo,
    StLenHi,
    StLo,
    StHi,
    StCk0,
    StCk1
  } step_e;

  // Configuration registers.
  logic [7:0] src_addr_q, dst_addr_q;

  // Frame control state, updated when an item is accepted.
  logic            frame_open_q, frame_open_d;
  logic [CntW-1:0] remaining_q, remaining_d;

  // Sequencer job register.
  logic        job_valid_q, job_valid_d;
  step_e       step_q, step_d;
  logic [7:0]  job_id_q;
  logic [15:0] job_len_q;
  logic [15:0] job_word_q;
  logic        job_last_q;

  // Running checksums.
  logic [7:0] byte_sum_q, byte_sum_d;
  logic [7:0] sos_q, sos_d;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       frame_end_q;

  // Handshake and control signals.
  logic            out_adv, emit, job_done, accept, load_job;
  logic            item_last;
  logic [CntW-1:0] count_sat;
  logic [15:0]     frame_len;
  logic [7:0]      seq_byte;
  logic            seq_is_data;
  logic [7:0]      sum_base, sos_base;
  step_e           step_next;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= SourceAddrReset;
      dst_addr_q <= DestAddrReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSourceAddr: src_addr_q <= cfg_data_i;
        RegDestAddr:   dst_addr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshakes: the output register moves when empty or taken, and a new
  // item enters as the sequencer emits the last byte of the current one.
  assign out_adv  = !out_valid_q || !out_stall_i;
  assign emit     = job_valid_q && out_adv;
  assign job_done = emit && (step_q == StHi || step_q == StCk1);
  assign in_stall_o = job_valid_q && !job_done;
  assign accept   = in_valid_i && !in_stall_o;
  assign load_job = accept && (start_frame_i || frame_open_q);

  // Item count clamped to one..MAX_ITEMS, and the resulting payload length.
  always_comb begin
    if (item_count_i == 8'd0) begin
      count_sat = CntW'(1);
    end else if (item_count_i > 8'(MAX_ITEMS)) begin
      count_sat = CntW'(MAX_ITEMS);
    end else begin
      count_sat = CntW'(item_count_i);
    end
    frame_len = (16'(count_sat - CntW'(1)) << 1) | 16'd1;
  end

  // Frame control: decide whether this item is the last one of its frame.
  always_comb begin
    frame_open_d = frame_open_q;
    remaining_d  = remaining_q;
    item_last    = 1'b0;
    if (start_frame_i) begin
      item_last = (count_sat == CntW'(1));
    end else begin
      item_last = (remaining_q <= CntW'(1));
    end
    if (load_job) begin
      if (item_last) begin
        frame_open_d = 1'b0;
        remaining_d  = '0;
      end else begin
        frame_open_d = 1'b1;
        remaining_d  = start_frame_i ? (count_sat - CntW'(1)) : (remaining_q - CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remaining_q  <= '0;
    end else if (accept) begin
      frame_open_q <= frame_open_d;
      remaining_q  <= remaining_d;
    end
  end

  // Byte selection for the current sequencer position.
  always_comb begin
    seq_is_data = 1'b1;
    step_next   = StSync;
    case (step_q)
      StSync: begin
        seq_byte  = FrameSync;
        step_next = StSrc;
      end
      StSrc: begin
        seq_byte  = src_addr_q;
        step_next = StDst;
      end
      StDst: begin
        seq_byte  = dst_addr_q;
        step_next = StId;
      end
      StId: begin
        seq_byte  = job_id_q;
        step_next = StLenLo;
      end
      StLenLo: begin
        seq_byte  = job_len_q[7:0];
        step_next = StLenHi;
      end
      StLenHi: begin
        seq_byte  = job_len_q[15:8];
        step_next = StLo;
      end
      StLo: begin
        seq_byte  = job_word_q[7:0];
        step_next = job_last_q ? StCk0 : StHi;
      end
      StHi: begin
        seq_byte  = job_word_q[15:8];
      end
      StCk0: begin
        seq_byte    = byte_sum_q;
        seq_is_data = 1'b0;
        step_next   = StCk1;
      end
      StCk1: begin
        seq_byte    = sos_q;
        seq_is_data = 1'b0;
      end
      default: begin
        seq_byte    = 8'd0;
        seq_is_data = 1'b0;
      end
    endcase
  end

  // Running sums restart on the sync byte; checksum bytes are not summed.
  always_comb begin
    sum_base   = (step_q == StSync) ? 8'd0 : byte_sum_q;
    sos_base   = (step_q == StSync) ? 8'd0 : sos_q;
    byte_sum_d = sum_base + seq_byte;
    sos_d      = sos_base + byte_sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_sum_q <= 8'd0;
      sos_q      <= 8'd0;
    end else if (emit && seq_is_data) begin
      byte_sum_q <= byte_sum_d;
      sos_q      <= sos_d;
    end
  end

  // Sequencer job register.
  always_comb begin
    job_valid_d = job_valid_q;
    step_d      = step_q;
    if (load_job) begin
      job_valid_d = 1'b1;
      step_d      = start_frame_i ? StSync : StLo;
    end else if (job_done) begin
      job_valid_d = 1'b0;
    end else if (emit) begin
      step_d = step_next;
    end
  end

  // Sequencer state and the output register it feeds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      step_q      <= StSync;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      frame_end_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      step_q      <= step_d;
      if (out_adv) begin
        out_valid_q <= emit;
      end
      if (emit) begin
        out_byte_q  <= seq_byte;
        frame_end_q <= (step_q == StCk1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      job_id_q   <= frame_id_i;
      job_len_q  <= frame_len;
      job_word_q <= payload_value_i;
      job_last_q <= item_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

  // An idle sequencer never holds off the input.
  a_idle_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_q |-> !in_stall_o)
    else $error("input stalled with no job in the sequencer");

  // Checksum bytes belong only to the final item of a frame.
  a_ck_only_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && (step_q == StCk0 || step_q == StCk1)) |-> job_last_q)
    else $error("checksum emitted for an item that does not close its frame");

  // A closed frame has no items outstanding.
  a_closed_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_open_q |-> (remaining_q == '0))
    else $error("items outstanding while no frame is open");

endmodule : telemetry_frame_builder

>>> tb/tfb_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// tfb_scoreboard_pkg: frame predictor and byte checker for the frame builder.
// Rebuilds every frame from the accepted input words, with the header, the
// payload bytes and both running checksums, and compares the output byte
// stream against it in order.
// ----------------------------------------------------------------------------
package tfb_scoreboard_pkg;

  import tfb_pkg::*;

  // Largest payload item count that a frame can carry.
  localparam int unsigned MaxItems = 128;

  // One predicted output word: frame byte and end-of-frame flag.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  class tfb_frame_scoreboard;

    logic [7:0]  src_addr;
    logic [7:0]  dst_addr;
    logic [7:0]  byte_sum;
    logic [7:0]  sum_of_sums;
    logic [7:0]  items_left;
    bit          frame_open;
    frame_byte_t pending[$];
    int unsigned err_count;

    function new();
      src_addr    = SourceAddrReset;
      dst_addr    = DestAddrReset;
      byte_sum    = '0;
      sum_of_sums = '0;
      items_left  = '0;
      frame_open  = 1'b0;
      err_count   = 0;
    endfunction

    // Register write as the block sees it; unused indexes change nothing.
    function void write_register(logic [CfgIdxW-1:0] idx, logic [7:0] data);
      if (idx == RegSourceAddr) begin
        src_addr = data;
      end else if (idx == RegDestAddr) begin
        dst_addr = data;
      end
    endfunction

    // Queue one frame byte and fold it into both running sums.
    function void add_byte(logic [7:0] b);
      byte_sum    = byte_sum + b;
      sum_of_sums = sum_of_sums + byte_sum;
      pending.push_back('{value: b, last: 1'b0});
    endfunction

    // Append the two checksum bytes and return to idle.
    function void close_frame();
      pending.push_back('{value: byte_sum, last: 1'b0});
      pending.push_back('{value: sum_of_sums, last: 1'b1});
      frame_open = 1'b0;
      items_left = '0;
    endfunction

    // Work out the bytes that one accepted input word causes.
    function void note_item(bit start, logic [7:0] id, logic [7:0] count,
                            logic [15:0] word);
      int unsigned n;
      logic [15:0] len;
      if (start) begin
        // A zero count means one item; large counts saturate.
        n = count;
        if (n == 0) n = 1;
        if (n > MaxItems) n = MaxItems;
        len = 16'(2 * (n - 1) + 1);
        // A new start drops any open frame and restarts the sums.
        byte_sum    = '0;
        sum_of_sums = '0;
        add_byte(FrameSync);
        add_byte(src_addr);
        add_byte(dst_addr);
        add_byte(id);
        add_byte(len[7:0]);
        add_byte(len[15:8]);
        add_byte(word[7:0]);
        if (n == 1) begin
          close_frame();
        end else begin
          add_byte(word[15:8]);
          items_left = 8'(n - 1);
          frame_open = 1'b1;
        end
      end else if (frame_open) begin
        add_byte(word[7:0]);
        if (items_left <= 1) begin
          close_frame();
        end else begin
          add_byte(word[15:8]);
          items_left = items_left - 1;
        end
      end
      // A non-start word while idle is dropped by the block.
    endfunction

    // Compare one accepted output word with the oldest prediction.
    function void check_byte(logic [7:0] b, logic fe);
      frame_byte_t exp_byte;
      if (pending.size() == 0) begin
        $error("unexpected output word: out_byte %02h, frame_end %0b", b, fe);
        err_count++;
        return;
      end
      exp_byte = pending.pop_front();
      if (b !== exp_byte.value) begin
        $error("out_byte: expected %02h, got %02h", exp_byte.value, b);
        err_count++;
      end
      if (fe !== exp_byte.last) begin
        $error("frame_end: expected %0b, got %0b", exp_byte.last, fe);
        err_count++;
      end
    endfunction

  endclass

endpackage : tfb_scoreboard_pkg

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the telemetry frame builder.
// Drives directed frames covering the corner cases and then random frames
// under several address settings, with random gaps on the input and random
// stalls on the output, and checks every output byte against the predictor.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tfb_pkg::*;
  import tfb_scoreboard_pkg::*;

  // Register indexes that the block does not implement.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  // Cycles allowed for the block to finish a word that makes no bytes.
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseItems  = 95;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [7:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 start_frame_i;
  logic [7:0]           frame_id_i;
  logic [7:0]           item_count_i;
  logic [15:0]          payload_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [7:0]           out_byte_o;
  logic                 frame_end_o;

  tfb_frame_scoreboard  frames = new();
  bit                   quiet;
  int unsigned          stall_hold;
  int unsigned          stall_pick;
  int unsigned          words_sent;

  telemetry_frame_builder #(
    .MAX_ITEMS       (MaxItems)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .start_frame_i   (start_frame_i),
    .frame_id_i      (frame_id_i),
    .item_count_i    (item_count_i),
    .payload_value_i (payload_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .frame_end_o     (frame_end_o)
  );

  // Free-running 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Hard limit on the length of the run.
  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  // Receiver stalls: mostly short, now and then long, none while quiet.
  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (quiet) begin
      out_stall_i = 1'b0;
    end else if (out_stall_i) begin
      out_stall_i = 1'b0;
      stall_hold  = $urandom_range(0, 12);
    end else begin
      stall_pick  = $urandom_range(0, 99);
      out_stall_i = 1'b1;
      stall_hold  = (stall_pick < 85) ? $urandom_range(0, 2) : $urandom_range(8, 30);
    end
  end

  // Check every output word that the receiver takes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      frames.check_byte(out_byte_o, frame_end_o);
    end
  end

  // Sender gap before a word: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one input word and wait until the block takes it.
  task automatic send_item(bit start, logic [7:0] id, logic [7:0] count,
                           logic [15:0] word);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    start_frame_i   = start;
    frame_id_i      = id;
    item_count_i    = count;
    payload_value_i = word;
    do @(posedge clk_i); while (in_stall_o);
    frames.note_item(start, id, count, word);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Write one configuration register.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Let every predicted byte drain and the block fall idle.
  task automatic settle();
    in_valid_i = 1'b0;
    while (frames.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One random frame; it is cut short now and then to exercise abandonment.
  task automatic send_frame(logic [7:0] count);
    int unsigned n;
    int unsigned k;
    n = (count == 0) ? 1 : ((count > MaxItems) ? MaxItems : count);
    send_item(1'b1, 8'($urandom), count, 16'($urandom));
    for (k = 1; k < n; k++) begin
      if ($urandom_range(0, 99) < 3) return;
      send_item(1'b0, 8'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  // Random traffic until the phase has sent its share of words.
  task automatic random_phase(bit with_long_frame);
    int unsigned r;
    int unsigned target;
    target = words_sent + PhaseItems;
    if (with_long_frame) send_frame($urandom_range(0, 1) ? 8'd128 : 8'd255);
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // Stray word: dropped when idle, taken as payload inside a frame.
        send_item(1'b0, 8'($urandom), 8'($urandom), 16'($urandom));
      end else if (r < 13) begin
        send_frame(8'd0);
      end else if (r < 50) begin
        send_frame(8'($urandom_range(1, 3)));
      end else if (r < 90) begin
        send_frame(8'($urandom_range(4, 12)));
      end else begin
        send_frame(8'($urandom_range(13, 40)));
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = RegSourceAddr;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    start_frame_i   = 1'b0;
    frame_id_i      = '0;
    item_count_i    = '0;
    payload_value_i = '0;
    out_stall_i     = 1'b0;
    stall_hold      = 0;
    quiet           = 1'b0;
    words_sent      = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames with the reset addresses.
    // Single-item frame, all-ones payload.
    send_item(1'b1, 8'h00, 8'd1, 16'hFFFF);
    // Stray word while idle is dropped.
    send_item(1'b0, 8'hFF, 8'hFF, 16'h1234);
    // Zero count behaves as one item.
    send_item(1'b1, 8'hFF, 8'd0, 16'h0000);
    // Three-item frame: start, middle, final.
    send_item(1'b1, 8'h5A, 8'd3, 16'hA55A);
    send_item(1'b0, 8'h00, 8'h00, 16'h1234);
    send_item(1'b0, 8'h00, 8'h00, 16'hFFFF);
    // Saturating count, then abandoned by a fresh start.
    send_item(1'b1, 8'h81, 8'd255, 16'h0F0F);
    send_item(1'b0, 8'h00, 8'h00, 16'h00FF);
    send_item(1'b1, 8'h3C, 8'd2, 16'hFF00);
    send_item(1'b0, 8'h00, 8'h00, 16'h00A5);
    settle();

    // Writes to unused indexes leave the addresses alone.
    write_reg(RegSpareLo, 8'hA5);
    write_reg(RegSpareHi, 8'h5A);
    send_item(1'b1, 8'hC3, 8'd1, 16'h7E81);
    settle();

    // Random phases under several address settings.
    write_reg(RegSourceAddr, 8'h00);
    write_reg(RegDestAddr, 8'hFF);
    random_phase(1'b0);
    settle();

    write_reg(RegSourceAddr, 8'hFF);
    write_reg(RegDestAddr, 8'h00);
    random_phase(1'b1);
    settle();

    // A stretch with no gaps and no stalls.
    write_reg(RegSourceAddr, 8'($urandom));
    write_reg(RegDestAddr, 8'($urandom));
    quiet = 1'b1;
    random_phase(1'b0);
    settle();
    quiet = 1'b0;

    write_reg(RegSourceAddr, SourceAddrReset);
    write_reg(RegDestAddr, 8'($urandom));
    random_phase(1'b0);
    settle();

    if (frames.err_count == 0 && frames.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule : tb_top
